// ===== rtl/stepper_step_dir_generator_top_macros.svh =====
// assertion macros for the step/dir generator
`ifndef STEPPER_STEP_DIR_GENERATOR_TOP_MACROS_SVH
`define STEPPER_STEP_DIR_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SDG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdg assertion failed");
`define SDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdg assertion failed");
`else
`define SDG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/sdg_pkg.sv =====
// shared types and constants of the step/dir generator
package sdg_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [15:0] PERIOD_NUMERATOR = 16'd60000;
	localparam logic [14:0] PERIOD_MAX = 15'h7fff;
	localparam logic [5:0] FACTOR_RESET = 6'd1;

	localparam int unsigned DIVISOR_W = 22;
	localparam int unsigned QUOTIENT_W = 16;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_CW   = 2'd1,
		MODE_CCW  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_START,
		B_WAIT,
		B_FIN
	} bstate_t;

	// classified command held in the queue
	typedef struct packed {
		logic        is_speed;
		logic        negative;
		logic        is_zero;
		logic [15:0] mag;
	} cmd_t;

	typedef struct packed {
		logic                 start;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [QUOTIENT_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/sdg_front.sv =====
// input side: accepts items, classifies them and queues them for the back end
module sdg_front #(
	parameter int unsigned Depth = sdg_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [15:0]   s_axis_tdata,
	input  logic          s_axis_tuser,
	output logic          q_valid,
	output sdg_pkg::cmd_t q_cmd,
	input  logic          q_pop
);
	import sdg_pkg::*;

	localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	cmd_t            cmd_in;
	logic            push;

	always_comb begin
		cmd_in.is_speed = s_axis_tuser;
		cmd_in.negative = s_axis_tdata[15];
		cmd_in.is_zero  = (s_axis_tdata == 16'd0);
		cmd_in.mag      = s_axis_tdata[15] ? 16'(~s_axis_tdata + 16'd1) : s_axis_tdata;
	end

	assign s_axis_tready = (count_q != CntW'(Depth));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != '0);
	assign q_cmd         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == IdxW'(Depth - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (q_pop) begin
				if (rd_ptr_q == IdxW'(Depth - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sdg_divider.sv =====
// restoring divider of the fixed numerator by the speed term, one bit per cycle
module sdg_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  sdg_pkg::div_req_t req,
	output sdg_pkg::div_rsp_t rsp
);
	import sdg_pkg::*;

	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [QUOTIENT_W-1:0] num_q;
	logic [QUOTIENT_W-1:0] quo_q;
	logic [4:0]            cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_sub;
	logic                  ge;

	assign rem_sh  = {rem_q, num_q[QUOTIENT_W-1]};
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign ge      = (rem_sh >= {1'b0, divisor_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			rem_q     <= '0;
			num_q     <= PERIOD_NUMERATOR;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
			num_q <= {num_q[QUOTIENT_W-2:0], 1'b0};
			quo_q <= {quo_q[QUOTIENT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QUOTIENT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/sdg_back.sv =====
// execution side: pulse counter, speed update sequencer and output register
`include "stepper_step_dir_generator_top_macros.svh"

module sdg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [5:0]        cfg_data,
	input  logic              q_valid,
	input  sdg_pkg::cmd_t     q_cmd,
	output logic              q_pop,
	output sdg_pkg::div_req_t div_req,
	input  sdg_pkg::div_rsp_t div_rsp,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata // pulse_level, direction_level, running, zero fill
);
	import sdg_pkg::*;

	bstate_t     state_q;
	bstate_t     state_d;
	logic [5:0]  factor_q;
	logic [15:0] cnt_q;
	logic [14:0] period_q;
	logic [13:0] high_q;
	mode_t       mode_q;
	logic        pulse_q;
	logic        dir_q;
	logic        neg_q;
	logic [15:0] mag_q;
	logic [DIVISOR_W-1:0] prod_q;
	logic        m_valid_q;
	logic [2:0]  m_data_q;

	logic        slot_free;
	logic        pop_tick;
	logic        pop_stop;
	logic        pop_speed;
	logic        mul_en;
	logic        div_start;
	logic        finish;
	logic        load_out;

	logic [15:0] cnt_inc;
	logic        pulse_next;
	logic [15:0] cnt_next;
	logic [14:0] q_sat;
	logic        pulse_new;
	logic        dir_new;
	mode_t       mode_new;

	assign slot_free = !m_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid && slot_free && q_cmd.is_speed && !q_cmd.is_zero) begin
					state_d = B_MUL;
				end
			end
			B_MUL:   state_d = B_START;
			B_START: state_d = B_WAIT;
			B_WAIT: begin
				if (div_rsp.done) begin
					state_d = B_FIN;
				end
			end
			B_FIN: begin
				if (slot_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop_tick  = 1'b0;
		pop_stop  = 1'b0;
		pop_speed = 1'b0;
		mul_en    = 1'b0;
		div_start = 1'b0;
		finish    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid && slot_free) begin
					pop_tick  = !q_cmd.is_speed;
					pop_stop  = q_cmd.is_speed && q_cmd.is_zero;
					pop_speed = q_cmd.is_speed && !q_cmd.is_zero;
				end
			end
			B_MUL:   mul_en = 1'b1;
			B_START: div_start = 1'b1;
			B_WAIT:  ;
			B_FIN:   finish = slot_free;
			default: ;
		endcase
	end

	assign q_pop    = pop_tick || pop_stop || pop_speed;
	assign load_out = pop_tick || pop_stop || finish;

	assign div_req.start   = div_start;
	assign div_req.divisor = prod_q;

	// tick arithmetic
	assign cnt_inc    = cnt_q + 16'd1;
	assign pulse_next = (cnt_inc <= {2'b00, high_q});
	assign cnt_next   = (cnt_inc >= {1'b0, period_q}) ? 16'd0 : cnt_inc;

	assign q_sat = div_rsp.quotient[15] ? PERIOD_MAX : div_rsp.quotient[14:0];

	always_comb begin
		pulse_new = pulse_q;
		dir_new   = dir_q;
		mode_new  = mode_q;
		if (pop_tick && (mode_q != MODE_STOP)) begin
			pulse_new = pulse_next;
		end
		if (pop_stop) begin
			mode_new = MODE_STOP;
		end
		if (finish) begin
			dir_new  = neg_q;
			mode_new = neg_q ? MODE_CCW : MODE_CW;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_speed) begin
			mag_q <= q_cmd.mag;
			neg_q <= q_cmd.negative;
		end
		if (mul_en) begin
			prod_q <= {6'd0, mag_q} * {16'd0, factor_q};
		end
		if (load_out) begin
			m_data_q <= {(mode_new != MODE_STOP), dir_new, pulse_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			factor_q  <= FACTOR_RESET;
			cnt_q     <= '0;
			period_q  <= '0;
			high_q    <= '0;
			mode_q    <= MODE_STOP;
			pulse_q   <= 1'b0;
			dir_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				factor_q <= cfg_data;
			end
			if (pop_tick && (mode_q != MODE_STOP)) begin
				cnt_q <= cnt_next;
			end
			if (finish) begin
				period_q <= q_sat;
				high_q   <= q_sat[14:1];
			end
			mode_q  <= mode_new;
			pulse_q <= pulse_new;
			dir_q   <= dir_new;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, m_data_q};

	`SDG_ASSERT_IMPLIES(a_high_half, clk, arst_n, 1'b1, high_q == period_q[14:1])
	`SDG_ASSERT_IMPLIES(a_div_done, clk, arst_n, div_rsp.done, state_q == B_WAIT)
	`SDG_ASSERT_NEXT(a_run_flag, clk, arst_n, load_out, m_data_q[2] == (mode_q != MODE_STOP))

endmodule

// ===== rtl/stepper_step_dir_generator_top.sv =====
// top level of the stepper step/dir pulse generator
// Each input transfer is either a timer tick (tuser 0) or a new speed in rpm (tuser 1, tdata
// signed) and yields exactly one output transfer with the pulse, direction and running
// levels after that item. A tick is handled directly in the idle state of the back end.
// A nonzero speed holds the back end through the queue pop, the multiply, the divider
// start, the 16 steps of the restoring divider, its done flag and the commit, which waits
// for a free output register. A small input queue keeps taking items while a speed
// update is in progress, and the output register holds a finished result until it is
// taken. The microstep factor is written through the cfg channel, which is always ready.
module stepper_step_dir_generator_top #(
	parameter int unsigned QueueDepth = sdg_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // speed_rpm
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // pulse_level, direction_level, running, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	import sdg_pkg::*;

	logic     q_valid;
	cmd_t     q_cmd;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	sdg_front #(
		.Depth(QueueDepth)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop)
	);

	sdg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sdg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the stepper step/dir pulse generator
`timescale 1ns / 1ps

module testbench;
	import sdg_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PRINT_CAP = 40;

	typedef struct packed {
		logic running;
		logic direction;
		logic pulse;
	} step_levels_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // speed_rpm
	logic        s_axis_tuser;   // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // pulse_level, direction_level, running, zero fill
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;

	// motor state as predicted by the bench
	logic [5:0]  factor;
	logic [15:0] count;
	logic [14:0] period;
	logic [13:0] high_time;
	mode_t       mode;
	logic        pulse;
	logic        dir;

	step_levels_t levels_due[$];
	bit           calm;
	int unsigned  mismatches;
	int unsigned  tick_items;
	int unsigned  speed_items;
	int unsigned  settings_done;
	int unsigned  stall_cycles;

	stepper_step_dir_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic advance_motor(input logic kind, input logic [15:0] rpm);
		int unsigned mag;
		int unsigned divisor;
		int unsigned quotient;
		step_levels_t lv;
		if (kind) begin
			speed_items++;
			mag = rpm[15] ? (32'h10000 - rpm) : rpm;
			if (mag == 0) begin
				mode = MODE_STOP;
			end else begin
				divisor = mag * factor;
				quotient = (divisor == 0) ? 32767 : 60000 / divisor;
				if (quotient > 32767)
					quotient = 32767;
				period = quotient[14:0];
				high_time = quotient[14:1];
				mode = rpm[15] ? MODE_CCW : MODE_CW;
				dir = rpm[15];
			end
		end else begin
			tick_items++;
			if (mode != MODE_STOP) begin
				count = count + 16'd1;
				pulse = (count <= {2'b00, high_time});
				if (count >= {1'b0, period})
					count = '0;
			end
		end
		lv.pulse = pulse;
		lv.direction = dir;
		lv.running = (mode != MODE_STOP);
		levels_due.push_back(lv);
	endtask

	task automatic send_item(input logic kind, input logic [15:0] rpm);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= rpm;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		advance_motor(kind, rpm);
	endtask

	task automatic send_tick();
		send_item(1'b0, 16'($urandom));
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (levels_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_factor(input logic [5:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		factor = value;
		settings_done++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
	endtask

	function automatic logic [15:0] pick_rpm();
		int unsigned roll;
		logic [15:0] r;
		roll = $urandom_range(99);
		if (roll < 40)
			r = 16'($urandom_range(32767, 600));
		else if (roll < 55)
			r = 16'($urandom_range(100, 1));
		else if (roll < 63)
			r = 16'd0;
		else if (roll < 68)
			r = 16'd32767;
		else if (roll < 72)
			return 16'h8000;
		else
			return 16'($urandom);
		if ($urandom_range(1))
			r = -r;
		return r;
	endfunction

	// output side: random back-pressure
	always @(negedge clk) begin
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		step_levels_t want;
		step_levels_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[2:0];
			if (levels_due.size() == 0) begin
				report_mismatch("unexpected transfer", m_axis_tdata, 0);
			end else begin
				want = levels_due.pop_front();
				if (got.pulse !== want.pulse)
					report_mismatch("pulse_level", got.pulse, want.pulse);
				if (got.direction !== want.direction)
					report_mismatch("direction_level", got.direction, want.direction);
				if (got.running !== want.running)
					report_mismatch("running", got.running, want.running);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic test_stopped_ticks();
		send_tick();
		send_tick();
	endtask

	task automatic test_speed_extremes();
		send_item(1'b1, 16'sd32767);
		send_tick();
		send_item(1'b1, 16'h8000);
		send_tick();
		send_item(1'b1, 16'hffff);
		send_tick();
		send_item(1'b1, 16'd1);
	endtask

	task automatic test_period_shrink();
		repeat (4) send_tick();
		send_item(1'b1, 16'd30000);
		repeat (2) send_tick();
	endtask

	task automatic test_zero_speed();
		send_item(1'b1, 16'd0);
		send_tick();
		send_item(1'b1, 16'd0);
	endtask

	task automatic test_very_high_speed();
		set_factor(6'd32);
		send_item(1'b1, 16'd20000);
		repeat (2) send_tick();
	endtask

	task automatic test_zero_factor();
		set_factor(6'd0);
		send_item(1'b1, 16'hff9c);
		repeat (2) send_tick();
	endtask

	task automatic test_random_phase(input logic [5:0] value, input int unsigned n, input bit quiet);
		set_factor(value);
		calm = quiet;
		repeat (n) begin
			if ($urandom_range(99) < 11)
				send_item(1'b1, pick_rpm());
			else
				send_tick();
		end
		calm = 1'b0;
	endtask

	initial begin
		factor = FACTOR_RESET;
		count = '0;
		period = '0;
		high_time = '0;
		mode = MODE_STOP;
		pulse = 1'b0;
		dir = 1'b0;
		calm = 1'b0;
		mismatches = 0;
		tick_items = 0;
		speed_items = 0;
		settings_done = 0;
		stall_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_stopped_ticks();
		test_speed_extremes();
		test_period_shrink();
		test_zero_speed();
		test_very_high_speed();
		test_zero_factor();

		test_random_phase(6'd1, 85, 1'b0);
		test_random_phase(6'd2, 85, 1'b0);
		test_random_phase(6'd4, 85, 1'b1);
		test_random_phase(6'd8, 85, 1'b0);
		test_random_phase(6'd16, 85, 1'b0);
		test_random_phase(6'd32, 85, 1'b0);
		test_random_phase(6'd0, 85, 1'b0);
		test_random_phase(6'd63, 85, 1'b0);
		test_random_phase(6'd3, 85, 1'b0);
		test_random_phase(6'($urandom_range(63)), 85, 1'b0);
		drain();

		$display("covered %0d ticks and %0d speed updates over %0d microstep settings",
			tick_items, speed_items, settings_done);
		$display("%0d mismatches, %0d transfers still outstanding", mismatches,
			levels_due.size());
		if (mismatches == 0 && levels_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
